### rtl/joystick_packet_deframer_unit_macros.svh
// Assertion helpers for the deframer checker.
`ifndef JOYSTICK_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define JOYSTICK_PACKET_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication.
`define JPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jpd check failed: same-cycle rule");

// Next-cycle implication.
`define JPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jpd check failed: next-cycle rule");

`endif

### rtl/jpd_pkg.sv
`default_nettype none
package jpd_pkg;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_HEADER = 2'd1,
		ST_COUNT  = 2'd2,
		ST_SUM    = 2'd3
	} frame_status_t;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BUTTONS   = 2'd2;

	localparam logic [7:0] FIRST_HEADER_RST  = 8'd85;
	localparam logic [7:0] SECOND_HEADER_RST = 8'd170;
	localparam logic [3:0] MAX_BUTTONS_RST   = 4'd6;

	localparam logic [4:0] BASE_LENGTH = 5'd10;
	localparam logic [7:0] CENTER      = 8'd127;
	localparam int         MASK_W      = 8;

	// Byte positions inside a frame (count of bytes taken so far).
	localparam logic [4:0] POS_SECOND_HEADER = 5'd2;
	localparam logic [4:0] POS_COUNT         = 5'd4;
	localparam logic [4:0] POS_FIRST_ID      = 5'd6;

endpackage
`default_nettype wire

### rtl/joystick_packet_deframer_unit.sv
// Channel | Handshake                   | Payload
// --------+-----------------------------+------------------------------------------------------
// rx      | rx_valid / rx_stall         | rx_byte
// status  | status_valid / status_stall | frame_status, joystick_x, joystick_y, pressed_buttons
// cfg     | cfg_wr_en                   | cfg_index, cfg_data
//
// One word per cycle sustained while status_stall allows: a byte is held in the input register,
// the frame logic runs on it there and a result lands in the output register.
// status_valid rises once the checksum byte's result is registered in the output register.
// arst_n resets the frame tracker, valid flags, config registers and held joystick state at once.
// A stalled result holds the output register; the input register then holds
// any word it has, with rx_stall high, so nothing is dropped or reordered.
`default_nettype none
module joystick_packet_deframer_unit #(
	parameter int NUM_BUTTONS = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// received bytes
	input  wire logic                          rx_valid,
	output logic                               rx_stall,
	input  wire logic [7:0]                    rx_byte,
	// frame results
	output logic                               status_valid,
	input  wire logic                          status_stall,
	output jpd_pkg::frame_status_t             frame_status,
	output logic [7:0]                         joystick_x,
	output logic [7:0]                         joystick_y,
	output logic [7:0]                         pressed_buttons,
	// configuration writes
	input  wire logic                          cfg_wr_en,
	input  wire logic [jpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data
);
	import jpd_pkg::*;

	// Ids at or above this limit are ignored (mask is only MASK_W wide).
	localparam logic [8:0] ID_LIMIT = 9'((NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W);

	// config registers
	logic [7:0] first_header_q;
	logic [7:0] second_header_q;
	logic [3:0] max_buttons_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame tracker
	logic       in_frame_q;
	logic [4:0] byte_index_q;
	logic [7:0] running_sum_q;
	logic [4:0] frame_length_q;
	logic       header_good_q;
	logic [7:0] frame_button_count_q;
	logic [7:0] prior_button_count_q;
	logic [7:0] pending_mask_q;
	logic [7:0] pending_x_q;
	logic [7:0] pending_y_q;
	logic [7:0] held_x_q;
	logic [7:0] held_y_q;
	logic [7:0] held_buttons_q;

	// next-state
	logic       in_frame_d;
	logic [4:0] byte_index_d;
	logic [7:0] running_sum_d;
	logic [4:0] frame_length_d;
	logic       header_good_d;
	logic [7:0] frame_button_count_d;
	logic [7:0] prior_button_count_d;
	logic [7:0] pending_mask_d;
	logic [7:0] pending_x_d;
	logic [7:0] pending_y_d;
	logic [7:0] held_x_d;
	logic [7:0] held_y_d;
	logic [7:0] held_buttons_d;

	logic          fire;
	frame_status_t status_d;
	logic          advance;
	logic          rx_accept;
	logic [4:0]    idx;
	logic [5:0]    idx_ext;
	logic [5:0]    len_ext;
	logic [7:0]    base_buttons;

	// The word in the input stage moves on whenever the output slot is free
	// or being emptied this cycle.
	assign advance   = valid_s1 && (!status_valid || !status_stall);
	assign rx_stall  = valid_s1 && !advance;
	assign rx_accept = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_header_q  <= FIRST_HEADER_RST;
			second_header_q <= SECOND_HEADER_RST;
			max_buttons_q   <= MAX_BUTTONS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FIRST_HEADER:  first_header_q  <= cfg_data;
				REG_SECOND_HEADER: second_header_q <= cfg_data;
				REG_MAX_BUTTONS:   max_buttons_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// Per-byte frame logic.
	assign idx     = byte_index_q + 5'd1;
	assign idx_ext = {1'b0, idx};
	assign len_ext = {1'b0, frame_length_q};

	always_comb begin
		in_frame_d           = in_frame_q;
		byte_index_d         = byte_index_q;
		running_sum_d        = running_sum_q;
		frame_length_d       = frame_length_q;
		header_good_d        = header_good_q;
		frame_button_count_d = frame_button_count_q;
		prior_button_count_d = prior_button_count_q;
		pending_mask_d       = pending_mask_q;
		pending_x_d          = pending_x_q;
		pending_y_d          = pending_y_q;
		held_x_d             = held_x_q;
		held_y_d             = held_y_q;
		held_buttons_d       = held_buttons_q;
		fire                 = 1'b0;
		status_d             = ST_OK;
		base_buttons         = held_buttons_q;

		if (!in_frame_q) begin
			// hunting for the start byte
			if (byte_s1 == first_header_q) begin
				in_frame_d     = 1'b1;
				byte_index_d   = 5'd1;
				running_sum_d  = byte_s1;
				frame_length_d = BASE_LENGTH;
				header_good_d  = 1'b0;
				pending_mask_d = '0;
				pending_x_d    = '0;
				pending_y_d    = '0;
			end
		end else if (idx < frame_length_q) begin
			byte_index_d  = idx;
			running_sum_d = running_sum_q + byte_s1;
			if (idx == POS_SECOND_HEADER) begin
				header_good_d = (byte_s1 == second_header_q);
			end else if (idx == POS_COUNT) begin
				frame_length_d = (byte_s1 <= {4'd0, max_buttons_q})
					? BASE_LENGTH + byte_s1[4:0] : BASE_LENGTH;
				if (header_good_q) begin
					prior_button_count_d = frame_button_count_q;
					frame_button_count_d = byte_s1;
				end
			end else if (idx >= POS_FIRST_ID && idx_ext + 6'd5 <= len_ext) begin
				if ({1'b0, byte_s1} < ID_LIMIT) begin
					pending_mask_d = pending_mask_q | (8'd1 << byte_s1[2:0]);
				end
			end else if (idx_ext + 6'd4 == len_ext) begin
				pending_x_d = byte_s1;
			end else if (idx_ext + 6'd3 == len_ext) begin
				pending_y_d = byte_s1;
			end
		end else begin
			// checksum byte closes the frame
			fire         = 1'b1;
			in_frame_d   = 1'b0;
			byte_index_d = '0;
			priority if (!header_good_q) begin
				status_d = ST_HEADER;
			end else if (frame_button_count_q != {3'd0, frame_length_q} - {3'd0, BASE_LENGTH}) begin
				status_d = ST_COUNT;
			end else if (byte_s1 != running_sum_q) begin
				status_d = ST_SUM;
			end else begin
				status_d = ST_OK;
			end
			if (status_d == ST_OK) begin
				held_x_d = pending_x_q;
				held_y_d = pending_y_q;
				// zero-button frame after a nonzero one releases everything
				if (frame_button_count_q == '0 && prior_button_count_q != '0) begin
					base_buttons = '0;
				end
				held_buttons_d = base_buttons | pending_mask_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q           <= 1'b0;
			byte_index_q         <= '0;
			running_sum_q        <= '0;
			frame_length_q       <= BASE_LENGTH;
			header_good_q        <= 1'b0;
			frame_button_count_q <= '0;
			prior_button_count_q <= '0;
			pending_mask_q       <= '0;
			pending_x_q          <= '0;
			pending_y_q          <= '0;
			held_x_q             <= CENTER;
			held_y_q             <= CENTER;
			held_buttons_q       <= '0;
		end else if (advance) begin
			in_frame_q           <= in_frame_d;
			byte_index_q         <= byte_index_d;
			running_sum_q        <= running_sum_d;
			frame_length_q       <= frame_length_d;
			header_good_q        <= header_good_d;
			frame_button_count_q <= frame_button_count_d;
			prior_button_count_q <= prior_button_count_d;
			pending_mask_q       <= pending_mask_d;
			pending_x_q          <= pending_x_d;
			pending_y_q          <= pending_y_d;
			held_x_q             <= held_x_d;
			held_y_q             <= held_y_d;
			held_buttons_q       <= held_buttons_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid <= 1'b0;
		end else if (!status_valid || !status_stall) begin
			status_valid <= advance && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			frame_status    <= status_d;
			joystick_x      <= held_x_d;
			joystick_y      <= held_y_d;
			pressed_buttons <= held_buttons_d;
		end
	end

endmodule
`default_nettype wire

### rtl/jpd_checker.sv
`default_nettype none
`include "joystick_packet_deframer_unit_macros.svh"
module jpd_checker #(
	parameter int NUM_BUTTONS = 8
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   rx_valid,
	input wire logic                   rx_stall,
	input wire logic                   status_valid,
	input wire logic                   status_stall,
	input wire jpd_pkg::frame_status_t frame_status,
	input wire logic [7:0]             joystick_x,
	input wire logic [7:0]             joystick_y,
	input wire logic [7:0]             pressed_buttons
);
	import jpd_pkg::*;

	localparam int         LIM      = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;
	localparam logic [7:0] BTN_MASK = 8'((1 << LIM) - 1);

	logic [7:0] last_x_q;
	logic [7:0] last_y_q;
	logic [7:0] last_btn_q;
	logic       out_accept;
	logic       fail_out;

	assign out_accept = status_valid && !status_stall;
	assign fail_out   = status_valid && (frame_status != ST_OK);

	// last delivered joystick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q   <= CENTER;
			last_y_q   <= CENTER;
			last_btn_q <= '0;
		end else if (out_accept) begin
			last_x_q   <= joystick_x;
			last_y_q   <= joystick_y;
			last_btn_q <= pressed_buttons;
		end
	end

	// stalled result stays put (status, X and buttons)
	`JPD_ASSERT_NEXT(a_hold, clk, arst_n, status_valid && status_stall, status_valid && $stable(frame_status) && $stable(joystick_x) && $stable(pressed_buttons))

	// no button beyond the supported range is ever reported
	`JPD_ASSERT_NOW(a_btn_range, clk, arst_n, status_valid, (pressed_buttons & ~BTN_MASK) == 8'd0)

	// a failed frame leaves the joystick state as last reported
	`JPD_ASSERT_NOW(a_fail_keeps, clk, arst_n, fail_out, joystick_x == last_x_q && joystick_y == last_y_q && pressed_buttons == last_btn_q)

	// a word never waits at the input while the result side is free
	`JPD_ASSERT_NOW(a_no_idle_stall, clk, arst_n, rx_valid && rx_stall, status_valid && status_stall)

endmodule

bind joystick_packet_deframer_unit jpd_checker #(
	.NUM_BUTTONS(NUM_BUTTONS)
) u_jpd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rx_valid        (rx_valid),
	.rx_stall        (rx_stall),
	.status_valid    (status_valid),
	.status_stall    (status_stall),
	.frame_status    (frame_status),
	.joystick_x      (joystick_x),
	.joystick_y      (joystick_y),
	.pressed_buttons (pressed_buttons)
);
`default_nettype wire

### test/joystick_packet_deframer_unit_test.sv
module joystick_packet_deframer_unit_test;
	import jpd_pkg::*;

	localparam int ID_LIMIT = 8;
	// index 3 decodes to no register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// how a generated frame is damaged on purpose
	typedef enum int {
		FLAW_NONE,
		FLAW_SECOND,	// wrong second header
		FLAW_SUM,	// wrong checksum
		FLAW_ALL,	// wrong header and checksum: header must win
		FLAW_CUT	// tail dropped, next bytes get absorbed
	} frame_flaw_t;

	typedef struct {
		frame_status_t status;
		logic [7:0]    x;
		logic [7:0]    y;
		logic [7:0]    buttons;
	} frame_report_t;

	logic clk;
	logic arst_n = 1'b0;

	logic rx_valid = 1'b0;
	logic rx_stall;
	logic [7:0] rx_byte = 8'h00;

	logic status_valid;
	logic status_stall = 1'b0;
	frame_status_t frame_status;
	logic [7:0] joystick_x;
	logic [7:0] joystick_y;
	logic [7:0] pressed_buttons;

	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = 8'h00;

	joystick_packet_deframer_unit #(
		.NUM_BUTTONS(ID_LIMIT)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_byte        (rx_byte),
		.status_valid   (status_valid),
		.status_stall   (status_stall),
		.frame_status   (frame_status),
		.joystick_x     (joystick_x),
		.joystick_y     (joystick_y),
		.pressed_buttons(pressed_buttons),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// ---------------------------------------------------------------
	// Deframer shadow: register copy plus frame tracker state
	// ---------------------------------------------------------------
	logic [7:0] cfg_first  = FIRST_HEADER_RST;
	logic [7:0] cfg_second = SECOND_HEADER_RST;
	logic [3:0] cfg_maxb   = MAX_BUTTONS_RST;

	logic       fr_open   = 1'b0;
	logic [4:0] fr_pos    = 5'd0;
	logic [7:0] fr_sum    = 8'd0;
	logic [4:0] fr_len    = BASE_LENGTH;
	logic       fr_hdr_ok = 1'b0;
	logic [7:0] cnt_now   = 8'd0;	// count of the last frame with good headers
	logic [7:0] cnt_prev  = 8'd0;	// the one before it
	logic [7:0] id_mask   = 8'd0;
	logic [7:0] next_x    = 8'd0;
	logic [7:0] next_y    = 8'd0;
	logic [7:0] hold_x    = CENTER;
	logic [7:0] hold_y    = CENTER;
	logic [7:0] hold_btn  = 8'd0;

	frame_report_t report_q[$];	// reports owed by the block, oldest first
	logic [7:0]    byte_queue[$];	// bytes waiting for the driver
	logic [7:0]    id_stage[$];	// button ids forced into the next built frame

	int bytes_queued = 0;
	int bytes_sent = 0;
	int mismatches = 0;
	int phases = 0;
	int status_seen[4] = '{default: 0};

	// Advance the frame tracker by one accepted byte; on the checksum
	// byte the status and held joystick state go into report_q.
	task automatic deframe_byte(input logic [7:0] b);
		logic [4:0] pos;
		frame_status_t st;
		if (!fr_open) begin
			// hunting: only the start byte matters
			if (b == cfg_first) begin
				fr_open = 1'b1;
				fr_pos = 5'd1;
				fr_sum = b;
				fr_len = BASE_LENGTH;
				fr_hdr_ok = 1'b0;
				id_mask = 8'd0;
				next_x = 8'd0;
				next_y = 8'd0;
			end
		end else begin
			pos = fr_pos + 5'd1;
			fr_pos = pos;
			if (pos < fr_len) begin
				fr_sum = fr_sum + b;
				if (pos == POS_SECOND_HEADER) begin
					fr_hdr_ok = (b == cfg_second);
				end else if (pos == POS_COUNT) begin
					// over-limit counts fall back to the bare 10-byte layout
					fr_len = (b <= cfg_maxb) ? BASE_LENGTH + b[4:0] : BASE_LENGTH;
					if (fr_hdr_ok) begin
						cnt_prev = cnt_now;
						cnt_now = b;
					end
				end else if (pos >= POS_FIRST_ID && int'(pos) + 5 <= int'(fr_len)) begin
					if (int'(b) < ID_LIMIT && int'(b) < MASK_W)
						id_mask[b[2:0]] = 1'b1;
				end else if (int'(pos) + 4 == int'(fr_len)) begin
					next_x = b;
				end else if (int'(pos) + 3 == int'(fr_len)) begin
					next_y = b;
				end
			end else begin
				// checksum byte: header beats count beats sum
				if (!fr_hdr_ok)
					st = ST_HEADER;
				else if (int'(cnt_now) != int'(fr_len) - int'(BASE_LENGTH))
					st = ST_COUNT;
				else if (b != fr_sum)
					st = ST_SUM;
				else
					st = ST_OK;
				if (st == ST_OK) begin
					hold_x = next_x;
					hold_y = next_y;
					// a zero-button frame after a nonzero one releases everything
					if (cnt_now == 8'd0 && cnt_prev != 8'd0)
						hold_btn = 8'd0;
					hold_btn = hold_btn | id_mask;
				end
				fr_open = 1'b0;
				fr_pos = 5'd0;
				report_q.push_back('{st, hold_x, hold_y, hold_btn});
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	// Pause length: mostly none, some short, a few long.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Register write at the falling edge; shadow copy masks like the block.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_FIRST_HEADER: cfg_first = val;
			REG_SECOND_HEADER: cfg_second = val;
			REG_MAX_BUTTONS: cfg_maxb = val[3:0];
			default: ;
		endcase
	endtask

	// Build one frame at the current register settings. Ids come from
	// id_stage first, then random (mostly valid, some out of range).
	task automatic queue_frame(input logic [7:0] count, input frame_flaw_t flaw,
		input logic [7:0] jx, input logic [7:0] jy);
		logic [7:0] pkt[$];
		logic [7:0] sum;
		logic [7:0] id;
		int n_ids;
		int cut;
		n_ids = (count <= cfg_maxb) ? int'(count) : 0;
		pkt.push_back(cfg_first);
		if (flaw == FLAW_SECOND || flaw == FLAW_ALL)
			pkt.push_back(cfg_second ^ 8'($urandom_range(1, 255)));
		else
			pkt.push_back(cfg_second);
		pkt.push_back(8'($urandom_range(0, 255)));	// address
		pkt.push_back(count);
		pkt.push_back(8'($urandom_range(0, 255)));	// position
		for (int i = 0; i < n_ids; i++) begin
			if (id_stage.size() != 0)
				id = id_stage.pop_front();
			else if ($urandom_range(0, 7) == 0)
				id = 8'($urandom_range(8, 255));
			else
				id = 8'($urandom_range(0, 7));
			pkt.push_back(id);
		end
		id_stage.delete();
		pkt.push_back(jx);
		pkt.push_back(jy);
		pkt.push_back(8'($urandom_range(0, 255)));
		pkt.push_back(8'($urandom_range(0, 255)));
		sum = 8'd0;
		foreach (pkt[i])
			sum = sum + pkt[i];
		if (flaw == FLAW_SUM || flaw == FLAW_ALL)
			pkt.push_back(sum ^ 8'($urandom_range(1, 255)));
		else
			pkt.push_back(sum);
		if (flaw == FLAW_CUT) begin
			cut = $urandom_range(1, pkt.size() - 2);
			repeat (cut)
				void'(pkt.pop_back());
		end
		foreach (pkt[i])
			byte_queue.push_back(pkt[i]);
		bytes_queued += pkt.size();
	endtask

	// One random chunk: mostly well-formed frames, some damaged ones,
	// a little line noise between frames.
	task automatic queue_random_chunk();
		int roll;
		int n;
		int k;
		logic [7:0] b;
		frame_flaw_t flaw;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			k = $urandom_range(1, 6);
			repeat (k) begin
				b = 8'($urandom_range(0, 255));
				// noise rarely hits the start byte
				if (b == cfg_first && $urandom_range(0, 9) != 0)
					b = b ^ 8'h01;
				byte_queue.push_back(b);
			end
			bytes_queued += k;
		end else begin
			if ($urandom_range(0, 4) == 0) begin
				if (cfg_maxb < 4'd15 && $urandom_range(0, 2) != 0)
					n = $urandom_range(int'(cfg_maxb) + 1, 15);
				else
					n = $urandom_range(16, 255);
			end else if ($urandom_range(0, 3) == 0) begin
				n = 0;
			end else begin
				n = $urandom_range(0, int'(cfg_maxb));
			end
			roll = $urandom_range(0, 99);
			if (roll < 75)
				flaw = FLAW_NONE;
			else if (roll < 83)
				flaw = FLAW_SECOND;
			else if (roll < 91)
				flaw = FLAW_SUM;
			else if (roll < 95)
				flaw = FLAW_ALL;
			else
				flaw = FLAW_CUT;
			queue_frame(8'(n), flaw, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end
	endtask

	// Wait until every byte is taken and every report is back, then let
	// the pipe empty out before anyone touches the registers.
	task automatic settle();
		while (byte_queue.size() != 0 || rx_valid)
			@(posedge clk);
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// rx driver: new word at the falling edge once the last one is taken
	// ---------------------------------------------------------------
	logic rx_taken = 1'b0;
	int rx_gap = 0;
	int rx_calm = 0;	// words left in a run with no gaps

	always @(negedge clk) begin
		if (arst_n && (!rx_valid || rx_taken)) begin
			if (rx_gap > 0) begin
				rx_gap--;
				rx_valid <= 1'b0;
			end else if (byte_queue.size() != 0) begin
				rx_byte <= byte_queue.pop_front();
				rx_valid <= 1'b1;
				if (rx_calm > 0) begin
					rx_calm--;
				end else begin
					rx_gap = pause_len();
					if ($urandom_range(0, 59) == 0)
						rx_calm = $urandom_range(40, 160);
				end
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// accepted word goes straight into the shadow deframer
	always @(posedge clk) begin
		rx_taken <= arst_n && rx_valid && !rx_stall;
		if (arst_n && rx_valid && !rx_stall) begin
			deframe_byte(rx_byte);
			bytes_sent++;
		end
	end

	// ---------------------------------------------------------------
	// status receiver: random back-pressure, with calm stretches
	// ---------------------------------------------------------------
	int st_left = 0;
	int st_calm = 0;
	int st_roll;

	always @(negedge clk) begin
		if (st_left > 0) begin
			st_left--;
			status_stall <= 1'b1;
		end else if (st_calm > 0) begin
			st_calm--;
			status_stall <= 1'b0;
		end else begin
			st_roll = $urandom_range(0, 99);
			if (st_roll < 3) begin
				st_calm = $urandom_range(30, 150);
				status_stall <= 1'b0;
			end else if (st_roll < 20) begin
				st_left = pause_len();
				status_stall <= 1'b1;
			end else begin
				status_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// status checker: each accepted word against the oldest report
	// ---------------------------------------------------------------
	frame_report_t want;

	always @(posedge clk) begin
		if (arst_n && status_valid && !status_stall) begin
			if (report_q.size() == 0) begin
				$error("status word with no frame report pending");
				mismatches++;
			end else begin
				want = report_q.pop_front();
				status_seen[int'(want.status)]++;
				if (frame_status !== want.status) begin
					$error("frame_status: expected %0d, got %0d", want.status, frame_status);
					mismatches++;
				end
				if (joystick_x !== want.x) begin
					$error("joystick_x: expected %0d, got %0d", want.x, joystick_x);
					mismatches++;
				end
				if (joystick_y !== want.y) begin
					$error("joystick_y: expected %0d, got %0d", want.y, joystick_y);
					mismatches++;
				end
				if (pressed_buttons !== want.buttons) begin
					$error("pressed_buttons: expected %0h, got %0h", want.buttons,
						pressed_buttons);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence: reset, directed frames, then random phases
	// ---------------------------------------------------------------
	initial begin
		logic [7:0] f;
		logic [7:0] s;
		logic [7:0] m;
		int start;

		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// idle noise, none of it equal to the start byte
		byte_queue.push_back(8'h00);
		byte_queue.push_back(8'hFF);
		byte_queue.push_back(SECOND_HEADER_RST);
		bytes_queued += 3;
		// clean frames: extremes of X/Y, lowest and highest button
		id_stage = '{8'd0, 8'd7};
		queue_frame(8'd2, FLAW_NONE, 8'h00, 8'hFF);
		// count at the limit, with ids past the mask width ignored
		id_stage = '{8'd1, 8'd8, 8'd255, 8'd3, 8'd3, 8'd2};
		queue_frame(8'd6, FLAW_NONE, 8'hFF, 8'h00);
		// zero-button frame after a nonzero one: release all
		queue_frame(8'd0, FLAW_NONE, 8'h40, 8'hC0);
		// second zero frame: nothing to release
		queue_frame(8'd0, FLAW_NONE, 8'h01, 8'hFE);
		// count over the limit: short 10-byte frame, bad count
		queue_frame(8'd7, FLAW_NONE, 8'h12, 8'h34);
		queue_frame(8'd1, FLAW_SECOND, 8'h56, 8'h78);
		// header, count and sum all bad: header wins
		queue_frame(8'd9, FLAW_ALL, 8'h9A, 8'hBC);
		// bad sum still records its count, so the zero frame after releases
		id_stage = '{8'd4, 8'd5, 8'd6};
		queue_frame(8'd3, FLAW_SUM, 8'hDE, 8'hF0);
		queue_frame(8'd0, FLAW_NONE, 8'h11, 8'h22);
		// cut-off frame swallows the next one, then resync
		queue_frame(8'd2, FLAW_CUT, 8'h33, 8'h44);
		queue_frame(8'd1, FLAW_NONE, 8'h55, 8'h66);
		queue_frame(8'd1, FLAW_NONE, 8'h77, 8'h88);
		settle();

		// spare index ignored; max_buttons keeps only its low nibble
		write_reg(REG_SPARE, 8'h5A);
		write_reg(REG_MAX_BUTTONS, 8'hF0);
		queue_frame(8'd0, FLAW_NONE, 8'h99, 8'hAA);
		queue_frame(8'd1, FLAW_NONE, 8'hBB, 8'hCC);
		settle();

		// random phases, each with its own register setting
		while (bytes_queued < 1700) begin
			case (phases % 6)
				0: begin
					f = 8'h00;
					s = 8'hFF;
					m = 8'h0F;
				end
				1: begin
					f = 8'hFF;
					s = 8'h00;
					m = 8'h00;
				end
				2: begin
					f = 8'($urandom_range(0, 255));
					s = f;
					m = 8'($urandom_range(0, 255));
				end
				3: begin
					f = FIRST_HEADER_RST;
					s = SECOND_HEADER_RST;
					m = 8'(MAX_BUTTONS_RST);
				end
				default: begin
					f = 8'($urandom_range(0, 255));
					s = 8'($urandom_range(0, 255));
					m = 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(REG_FIRST_HEADER, f);
			write_reg(REG_SECOND_HEADER, s);
			write_reg(REG_MAX_BUTTONS, m);
			start = bytes_queued;
			while (bytes_queued - start < 240)
				queue_random_chunk();
			settle();
			phases++;
		end

		$display("Run covered %0d bytes in %0d register settings plus directed frames.",
			bytes_sent, phases);
		$display("Reports: ok %0d, bad header %0d, bad count %0d, checksum error %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### joystick_packet_deframer_unit.f
+incdir+rtl
rtl/jpd_pkg.sv
rtl/joystick_packet_deframer_unit.sv
rtl/jpd_checker.sv
test/joystick_packet_deframer_unit_test.sv
